FILE: src/ssh_pkg.sv
package ssh_pkg;

  // fixed-point constants
  localparam int FRAC_W = 24;
  localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
  localparam logic [23:0] LN2_Q24 = 24'd11629080;
  localparam logic [30:0] EXP_LIMIT_Q24 = 31'h4000_0000;
  localparam logic [31:0] ONE_PA_Q14 = 32'd16384;
  localparam logic [20:0] MAGNUS_K_Q16 = 21'd1158021;
  localparam logic [31:0] T_FREEZE_Q16 = 32'd17901158;
  localparam logic [31:0] T_MAGNUS_Q16 = 32'd1943142;
  localparam logic [31:0] E0_Q14 = 32'd10013901;
  localparam logic [23:0] EPS_RATIO_Q24 = 24'd10435428;
  // floor(2^38 / 100), used for the divide by one hundred
  localparam logic [31:0] RECIP100 = 32'd2748779069;
  localparam int RECIP_SHIFT = 38;

  // magnus divider geometry
  localparam int MAG_NUM_W = 61;
  localparam int MAG_QUO_W = 31;

  // register reset values
  localparam logic [31:0] RST_TEMP_SCALE = 32'd65536;
  localparam logic [31:0] RST_TEMP_OFFSET_K = 32'd18907545;
  localparam logic [31:0] RST_MIN_TEMP_K = 32'd9830400;
  localparam logic [31:0] RST_MAX_TEMP_K = 32'd22937600;
  localparam logic [31:0] RST_ALTITUDE_DECAY = 32'd16777216;
  localparam logic [31:0] RST_SEA_LEVEL_PRESSURE = 32'd1660108800;
  localparam logic [31:0] RST_MIN_HUMIDITY = 32'd0;
  localparam logic [31:0] RST_MAX_HUMIDITY = 32'd838861;

  // register indexes
  typedef enum logic [2:0] {
    CFG_TEMP_SCALE = 3'd0,
    CFG_TEMP_OFFSET_K = 3'd1,
    CFG_MIN_TEMP_K = 3'd2,
    CFG_MAX_TEMP_K = 3'd3,
    CFG_ALTITUDE_DECAY = 3'd4,
    CFG_SEA_LEVEL_PRESSURE = 3'd5,
    CFG_MIN_HUMIDITY = 3'd6,
    CFG_MAX_HUMIDITY = 3'd7
  } ssh_cfg_idx_e;

  typedef struct packed {
    logic [31:0] temp_scale;
    logic [31:0] temp_offset_k;
    logic [31:0] min_temp_k;
    logic [31:0] max_temp_k;
    logic [31:0] altitude_decay;
    logic [31:0] sea_level_pressure;
    logic [31:0] min_humidity;
    logic [31:0] max_humidity;
  } ssh_cfg_t;

  // data that rides along the magnus divider
  typedef struct packed {
    logic [31:0] kel;
    logic [30:0] x;
    logic        neg;
    logic        zero_den;
  } mag_side_t;

  // data that rides along the exponential unit
  typedef struct packed {
    logic [31:0] kel;
    logic        zero_den;
  } exp_side_t;

  // factor 2^(-2^-(k+1)) in Q0.32, elaboration only
  function automatic logic [31:0] pow2_factor(input int k);
    logic [63:0] c;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    c = 64'd3037000499;
    for (int i = 1; i < 16; i++) begin
      if (i <= k) begin
        n = c << 32;
        r = '0;
        for (int j = 31; j >= 0; j--) begin
          b = 64'd1 << (2 * j);
          if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
          end else begin
            r = r >> 1;
          end
        end
        c = r;
      end
    end
    return c[31:0];
  endfunction

endpackage

FILE: src/saturation_specific_humidity_top.sv
// throughput: one transaction per cycle; the whole pipeline advances unless the output
//   register holds a result that is stalled
// the two restoring dividers (magnus exponent, humidity) set the depth at one bit per stage
// reset: valid bits clear, configuration registers return to their defaults
module saturation_specific_humidity_top #(
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] model_temperature_i,
  input  logic [31:0] model_altitude_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] saturation_humidity_o,
  output logic [31:0] pressure_pa_o,
  output logic [31:0] kelvin_temperature_o,
  output logic        vapour_capped_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);
  import ssh_pkg::*;

  // configuration registers
  ssh_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_scale         <= RST_TEMP_SCALE;
      cfg_q.temp_offset_k      <= RST_TEMP_OFFSET_K;
      cfg_q.min_temp_k         <= RST_MIN_TEMP_K;
      cfg_q.max_temp_k         <= RST_MAX_TEMP_K;
      cfg_q.altitude_decay     <= RST_ALTITUDE_DECAY;
      cfg_q.sea_level_pressure <= RST_SEA_LEVEL_PRESSURE;
      cfg_q.min_humidity       <= RST_MIN_HUMIDITY;
      cfg_q.max_humidity       <= RST_MAX_HUMIDITY;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TEMP_SCALE:         cfg_q.temp_scale         <= cfg_wdata_i;
        CFG_TEMP_OFFSET_K:      cfg_q.temp_offset_k      <= cfg_wdata_i;
        CFG_MIN_TEMP_K:         cfg_q.min_temp_k         <= cfg_wdata_i;
        CFG_MAX_TEMP_K:         cfg_q.max_temp_k         <= cfg_wdata_i;
        CFG_ALTITUDE_DECAY:     cfg_q.altitude_decay     <= cfg_wdata_i;
        CFG_SEA_LEVEL_PRESSURE: cfg_q.sea_level_pressure <= cfg_wdata_i;
        CFG_MIN_HUMIDITY:       cfg_q.min_humidity       <= cfg_wdata_i;
        CFG_MAX_HUMIDITY:       cfg_q.max_humidity       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // global advance: hold everything only while a finished result waits
  logic en;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // kelvin, altitude and magnus numerator
  logic                  fr_valid;
  logic [MAG_NUM_W-1:0]  fr_num;
  logic [31:0]           fr_den;
  mag_side_t             fr_side;

  ssh_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (en),
    .valid_i            (in_valid_i),
    .model_temperature_i(model_temperature_i),
    .model_altitude_i   (model_altitude_i),
    .cfg_i              (cfg_q),
    .valid_o            (fr_valid),
    .mag_num_o          (fr_num),
    .mag_den_o          (fr_den),
    .side_o             (fr_side)
  );

  // magnus exponent divider
  logic                 md_valid;
  logic [MAG_QUO_W-1:0] md_quo;
  logic                 md_ovf;
  mag_side_t            md_side;

  ssh_div #(
    .NumW (MAG_NUM_W),
    .DenW (32),
    .QuoW (MAG_QUO_W),
    .SideW($bits(mag_side_t))
  ) u_mag_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(fr_valid),
    .num_i  (fr_num),
    .den_i  (fr_den),
    .side_i (fr_side),
    .valid_o(md_valid),
    .quo_o  (md_quo),
    .ovf_o  (md_ovf),
    .side_o (md_side)
  );

  // exponent saturation and lane setup
  logic [30:0] z;
  logic [30:0] mag  [2];
  logic        pos  [2];
  logic [31:0] base [2];
  exp_side_t   ex_side_in;

  assign z = (md_ovf || md_quo > EXP_LIMIT_Q24) ? EXP_LIMIT_Q24 : md_quo;

  assign mag[0]  = md_side.x;
  assign pos[0]  = 1'b1;
  assign base[0] = cfg_q.sea_level_pressure;
  assign mag[1]  = z;
  assign pos[1]  = md_side.neg;
  assign base[1] = E0_Q14;

  assign ex_side_in.kel      = md_side.kel;
  assign ex_side_in.zero_den = md_side.zero_den;

  // pressure and vapour exponentials
  logic        ex_valid;
  logic [31:0] ex_res [2];
  exp_side_t   ex_side;

  ssh_exp2 #(
    .TableBits(EXP_TABLE_BITS),
    .SideW    ($bits(exp_side_t))
  ) u_exp2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(md_valid),
    .mag_i  (mag),
    .pos_i  (pos),
    .base_i (base),
    .side_i (ex_side_in),
    .valid_o(ex_valid),
    .res_o  (ex_res),
    .side_o (ex_side)
  );

  // cap, humidity and output register
  ssh_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .en_i                 (en),
    .valid_i              (ex_valid),
    .press_i              (ex_res[0]),
    .vap_i                (ex_res[1]),
    .side_i               (ex_side),
    .min_humidity_i       (cfg_q.min_humidity),
    .max_humidity_i       (cfg_q.max_humidity),
    .valid_o              (out_valid_o),
    .saturation_humidity_o(saturation_humidity_o),
    .pressure_pa_o        (pressure_pa_o),
    .kelvin_temperature_o (kelvin_temperature_o),
    .vapour_capped_o      (vapour_capped_o)
  );

  // pressure floor reaches the port
  a_press_floor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pressure_pa_o >= ONE_PA_Q14)
    else $error("pressure below one pascal");

  // input held off only behind a waiting result
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  // a held result stays in place
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> out_valid_o)
    else $error("result lost while stalled");

endmodule

FILE: src/ssh_front.sv
module ssh_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [31:0]             model_temperature_i,
  input  logic signed [31:0]             model_altitude_i,
  input  ssh_pkg::ssh_cfg_t              cfg_i,
  output logic                           valid_o,
  output logic [ssh_pkg::MAG_NUM_W-1:0]  mag_num_o,
  output logic [31:0]                    mag_den_o,
  output ssh_pkg::mag_side_t             side_o
);
  import ssh_pkg::*;

  logic [2:0] valid_q;

  // stage 1: scale products
  logic signed [63:0] tprod_q;
  logic [62:0]        aprod_q;
  logic [30:0]        alt_pos;

  assign alt_pos = model_altitude_i[31] ? 31'd0 : model_altitude_i[30:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tprod_q <= 64'($signed(cfg_i.temp_scale)) * 64'(model_temperature_i);
      aprod_q <= 63'(alt_pos) * 63'(cfg_i.altitude_decay);
    end
  end

  // stage 2: kelvin clamp and altitude saturation
  logic signed [48:0] tsum;
  logic signed [48:0] tmin;
  logic signed [48:0] tmax;
  logic [46:0]        xs;
  logic [31:0]        kel_d, kel_q;
  logic [30:0]        x_d, x2_q;

  assign tsum = 49'($signed(cfg_i.temp_offset_k)) + 49'(tprod_q >>> 16);
  assign tmin = $signed({17'd0, cfg_i.min_temp_k});
  assign tmax = $signed({17'd0, cfg_i.max_temp_k});
  assign xs   = aprod_q[62:16];

  always_comb begin
    if (tsum < tmin) begin
      kel_d = cfg_i.min_temp_k;
    end else if (tsum > tmax) begin
      kel_d = cfg_i.max_temp_k;
    end else begin
      kel_d = tsum[31:0];
    end
    x_d = (xs > 47'(EXP_LIMIT_Q24)) ? EXP_LIMIT_Q24 : xs[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kel_q <= kel_d;
      x2_q  <= x_d;
    end
  end

  // stage 3: magnus numerator product and denominator
  logic signed [32:0] num, den;
  logic [31:0]        an, ad;
  logic [52:0]        nk_q;
  logic [31:0]        ad_q;
  mag_side_t          side_q;

  assign num = $signed({1'b0, kel_q}) - $signed({1'b0, T_FREEZE_Q16});
  assign den = $signed({1'b0, kel_q}) - $signed({1'b0, T_MAGNUS_Q16});
  assign an  = num[32] ? 32'(-num) : num[31:0];
  assign ad  = den[32] ? 32'(-den) : den[31:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nk_q            <= 53'(an) * 53'(MAGNUS_K_Q16);
      ad_q            <= ad;
      side_q.kel      <= kel_q;
      side_q.x        <= x2_q;
      side_q.neg      <= num[32] ^ den[32];
      side_q.zero_den <= (den == 33'sd0);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  assign valid_o   = valid_q[2];
  assign mag_num_o = {nk_q, 8'd0};
  assign mag_den_o = ad_q;
  assign side_o    = side_q;

endmodule

FILE: src/ssh_div.sv
module ssh_div #(
  parameter int NumW  = 61,
  parameter int DenW  = 32,
  parameter int QuoW  = 31,
  parameter int SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [QuoW-1:0]  quo_o,
  output logic             ovf_o,
  output logic [SideW-1:0] side_o
);

  logic [QuoW:0]      valid_q;
  logic [DenW-1:0]    rem_q  [QuoW+1];
  logic [DenW-1:0]    den_q  [QuoW+1];
  logic [QuoW-1:0]    low_q  [QuoW+1];
  logic [QuoW-1:0]    quo_q  [QuoW+1];
  logic               ovf_q  [QuoW+1];
  logic [SideW-1:0]   side_q [QuoW+1];

  // entry: upper dividend bits form the first remainder, overflow if quotient too wide
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= DenW'(num_i >> QuoW);
      den_q[0]  <= den_i;
      low_q[0]  <= num_i[QuoW-1:0];
      quo_q[0]  <= '0;
      ovf_q[0]  <= (num_i >> QuoW) >= NumW'(den_i);
      side_q[0] <= side_i;
    end
  end

  // one quotient bit per stage, restoring
  for (genvar i = 1; i <= QuoW; i++) begin : g_step
    logic [DenW:0] trial;
    logic          ge;

    assign trial = {rem_q[i-1], low_q[i-1][QuoW-i]};
    assign ge    = trial >= {1'b0, den_q[i-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? DenW'(trial - {1'b0, den_q[i-1]}) : trial[DenW-1:0];
        den_q[i]  <= den_q[i-1];
        low_q[i]  <= low_q[i-1];
        quo_q[i]  <= {quo_q[i-1][QuoW-2:0], ge};
        ovf_q[i]  <= ovf_q[i-1];
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[QuoW-1:0], valid_i};
    end
  end

  assign valid_o = valid_q[QuoW];
  assign quo_o   = quo_q[QuoW];
  assign ovf_o   = ovf_q[QuoW];
  assign side_o  = side_q[QuoW];

endmodule

FILE: src/ssh_exp2.sv
module ssh_exp2 #(
  parameter int TableBits = 8,
  parameter int SideW     = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [30:0]      mag_i  [2],
  input  logic             pos_i  [2],
  input  logic [31:0]      base_i [2],
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [31:0]      res_o  [2],
  output logic [SideW-1:0] side_o
);
  import ssh_pkg::*;

  localparam int RemW = FRAC_W - TableBits;
  localparam int Lat  = TableBits + 4;

  logic [Lat-1:0]   valid_q;
  logic [SideW-1:0] side_q [Lat];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [32:0]       pw_q [TableBits+1];
    logic [23:0]       g_q  [TableBits];
    logic signed [7:0] m_q  [TableBits+3];
    logic [32:0]       f_q  [TableBits];
    logic [32:0]       pr_q;
    logic [64:0]       v_q;
    logic [31:0]       res_q;
    logic [55:0]       yprod;
    logic [31:0]       w;
    logic [43:0]       lnprod;

    // base change to powers of two, split exponent
    assign yprod = 56'(mag_i[l]) * 56'(LOG2E_Q24);
    assign w     = pos_i[l] ? {1'b0, yprod[54:24]} : 32'(-{1'b0, yprod[54:24]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pw_q[0] <= 33'h1_0000_0000;
        g_q[0]  <= w[23:0];
        m_q[0]  <= $signed(w[31:24]);
      end
    end

    // linear factor for the bits below the table
    assign lnprod = 44'(g_q[0][RemW-1:0]) * 44'(LN2_Q24);

    // one table factor per stage
    for (genvar k = 0; k < TableBits; k++) begin : g_fac
      localparam logic [31:0] Fact = pow2_factor(k);
      logic [65:0] prod;

      assign prod = 66'(pw_q[k]) * 66'(Fact);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pw_q[k+1] <= g_q[k][FRAC_W-1-k] ? prod[64:32] : pw_q[k];
          m_q[k+1]  <= m_q[k];
        end
      end

      if (k == 0) begin : g_f_first
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            f_q[0] <= 33'h1_0000_0000 - 33'(lnprod >> 16);
          end
        end
      end else begin : g_f_pass
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            f_q[k] <= f_q[k-1];
          end
        end
      end

      if (k < TableBits - 1) begin : g_g_pass
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            g_q[k+1] <= g_q[k];
          end
        end
      end
    end

    // remainder factor, base product, final shift
    logic [65:0]       rprod;
    logic signed [8:0] sh;
    logic [64:0]       shifted;
    logic [31:0]       res_d;

    assign rprod   = 66'(pw_q[TableBits]) * 66'(f_q[TableBits-1]);
    assign sh      = 9'sd32 + 9'(m_q[TableBits+2]);
    assign shifted = v_q >> sh[5:0];

    always_comb begin
      if (v_q == 65'd0 || sh >= 9'sd64) begin
        res_d = 32'd0;
      end else if (sh < 9'sd0) begin
        res_d = '1;
      end else if (shifted > 65'hFFFF_FFFF) begin
        res_d = '1;
      end else begin
        res_d = shifted[31:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pr_q               <= rprod[64:32];
        m_q[TableBits+1]   <= m_q[TableBits];
        v_q                <= 65'(base_i[l]) * 65'(pr_q);
        m_q[TableBits+2]   <= m_q[TableBits+1];
        res_q              <= res_d;
      end
    end

    assign res_o[l] = res_q;
  end

  // side data shift line
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < Lat; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Lat-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[Lat-1];
  assign side_o  = side_q[Lat-1];

endmodule

FILE: src/ssh_back.sv
module ssh_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [31:0]        press_i,
  input  logic [31:0]        vap_i,
  input  ssh_pkg::exp_side_t side_i,
  input  logic [31:0]        min_humidity_i,
  input  logic [31:0]        max_humidity_i,
  output logic               valid_o,
  output logic [31:0]        saturation_humidity_o,
  output logic [31:0]        pressure_pa_o,
  output logic [31:0]        kelvin_temperature_o,
  output logic               vapour_capped_o
);
  import ssh_pkg::*;

  typedef struct packed {
    logic [31:0] p;
    logic [31:0] kel;
    logic        capped;
  } hum_side_t;

  // stage 1: pressure floor, cap test, reciprocal product for ceil(p / 100)
  logic [31:0] p_w, e_w;
  logic [32:0] v_w;
  logic        b1_valid_q, cap1_q;
  logic [31:0] p1_q, e1_q, kel1_q;
  logic [32:0] v1_q;
  logic [64:0] prod1_q;

  assign p_w = (press_i < ONE_PA_Q14) ? ONE_PA_Q14 : press_i;
  assign e_w = side_i.zero_den ? 32'd0 : vap_i;
  assign v_w = 33'(p_w) + 33'd99;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q    <= p_w;
      e1_q    <= e_w;
      cap1_q  <= (e_w >= p_w);
      v1_q    <= v_w;
      prod1_q <= 65'(v_w) * 65'(RECIP100);
      kel1_q  <= side_i.kel;
    end
  end

  // stage 2: quotient correction, capped vapour pressure
  logic [26:0] q0;
  logic [33:0] rem_w;
  logic [31:0] qc, ecap;
  logic        b2_valid_q, cap2_q;
  logic [31:0] p2_q, e2_q, kel2_q;

  assign q0    = prod1_q[64:RECIP_SHIFT];
  assign rem_w = 34'(v1_q) - 34'(q0) * 34'd100;
  assign qc    = 32'(q0) + ((rem_w >= 34'd100) ? 32'd1 : 32'd0);
  assign ecap  = p1_q - qc;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p2_q   <= p1_q;
      e2_q   <= cap1_q ? ecap : e1_q;
      cap2_q <= cap1_q;
      kel2_q <= kel1_q;
    end
  end

  // stage 3: humidity dividend and divisor
  logic        b3_valid_q;
  logic [55:0] hnum_q;
  logic [31:0] hden_q;
  hum_side_t   hside_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hnum_q         <= 56'(e2_q) * 56'(EPS_RATIO_Q24);
      hden_q         <= p2_q - e2_q;
      hside_q.p      <= p2_q;
      hside_q.kel    <= kel2_q;
      hside_q.capped <= cap2_q;
    end
  end

  // humidity divider
  logic        hd_valid;
  logic [31:0] hd_quo;
  logic        hd_ovf;
  hum_side_t   hd_side;

  ssh_div #(
    .NumW (56),
    .DenW (32),
    .QuoW (32),
    .SideW($bits(hum_side_t))
  ) u_hum_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .valid_i(b3_valid_q),
    .num_i  (hnum_q),
    .den_i  (hden_q),
    .side_i (hside_q),
    .valid_o(hd_valid),
    .quo_o  (hd_quo),
    .ovf_o  (hd_ovf),
    .side_o (hd_side)
  );

  // output stage: saturate and clamp humidity
  logic [31:0] qv, q_d;
  logic        out_valid_q;
  logic [31:0] hum_q, press_q, kel_q;
  logic        cap_q;

  assign qv = hd_ovf ? 32'hFFFF_FFFF : hd_quo;

  always_comb begin
    if (qv < min_humidity_i) begin
      q_d = min_humidity_i;
    end else if (qv > max_humidity_i) begin
      q_d = max_humidity_i;
    end else begin
      q_d = qv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hum_q   <= q_d;
      press_q <= hd_side.p;
      kel_q   <= hd_side.kel;
      cap_q   <= hd_side.capped;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      b3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      b1_valid_q  <= valid_i;
      b2_valid_q  <= b1_valid_q;
      b3_valid_q  <= b2_valid_q;
      out_valid_q <= hd_valid;
    end
  end

  assign valid_o               = out_valid_q;
  assign saturation_humidity_o = hum_q;
  assign pressure_pa_o         = press_q;
  assign kelvin_temperature_o  = kel_q;
  assign vapour_capped_o       = cap_q;

  // reciprocal estimate is off by at most one
  a_recip_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b1_valid_q |-> rem_w < 34'd200)
    else $error("ceil(p/100) remainder out of range");

  // divisor never reaches zero
  a_vap_below_p : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b2_valid_q |-> e2_q < p2_q)
    else $error("vapour pressure not below pressure");

endmodule
